/* rtl/fnv_open_address_hash_table_macros.svh */
// Assertion macros for the open-address hash table RTL.
// No dependencies; included by modules that carry assertions.
`ifndef FNV_OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`define FNV_OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
// Assert that a condition implies a property on the same edge.
`define FNV_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// Assert that a condition implies a property on the next edge.
`define FNV_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

/* rtl/fnvht_pkg.sv */
// Shared types and constants for the open-address hash table.
// No dependencies.
package fnvht_pkg;
  localparam logic [63:0] FNV_START = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_MULT  = 64'h00000100000001b3;
  localparam logic [1:0] ACT_SEARCH = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] mask;
    logic [63:0] hash;
  } cmd_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if ((i < n) || (i == 0)) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction
endpackage

/* rtl/fnvht_front.sv */
// Front part: accepts items and hashes the key one byte at a time, XOR state then multiply state.
// Depends on fnvht_pkg.
module fnvht_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [63:0]         key,
  input  logic [63:0]         value,
  input  logic [3:0]          key_bytes,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output fnvht_pkg::cmd_t     cmd
);
  import fnvht_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_XOR  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state;
  logic [3:0]  idx;
  logic [3:0]  nbytes;
  logic [63:0] prod_lo;
  logic [63:0] prod_hi;
  logic [7:0]  kbyte;

  assign in_ready  = (state == S_IDLE);
  assign cmd_valid = (state == S_OUT);
  assign kbyte = cmd.key[idx[2:0]*8 +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          state <= S_XOR;
        end
        S_XOR: state <= S_MUL;
        S_MUL: state <= (idx == nbytes) ? S_OUT : S_XOR;
        S_OUT: if (cmd_ready) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch the command on accept; per byte multiply by 2^40 + 0x1b3: a shift plus a narrow product, registered.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd.action <= action;
      cmd.key    <= key;
      cmd.value  <= value;
      cmd.mask   <= byte_mask(key_bytes);
      nbytes     <= (key_bytes == 4'd0) ? 4'd1 : ((key_bytes > 4'd8) ? 4'd8 : key_bytes);
      cmd.hash   <= FNV_START;
      idx        <= 4'd0;
    end else if (state == S_XOR) begin
      prod_lo <= (cmd.hash ^ {56'd0, kbyte}) * 64'h1b3;
      prod_hi <= {cmd.hash[23:8], cmd.hash[7:0] ^ kbyte, 40'd0};
      idx     <= idx + 4'd1;
    end else if (state == S_MUL) begin
      cmd.hash <= prod_lo + prod_hi;
    end
  end
endmodule

/* rtl/fnvht_queue.sv */
// Two-entry queue between front and back parts.
// Depends on fnvht_pkg.
module fnvht_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  fnvht_pkg::cmd_t  wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output fnvht_pkg::cmd_t  rd_data
);
  import fnvht_pkg::*;
  cmd_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wptr <= ~wptr;
      if (rd_valid && rd_ready) rptr <= ~rptr;
      count <= count + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end
endmodule

/* rtl/fnvht_back.sv */
// Back part: probes slots one at a time, reading then checking each, and updates the table.
// Depends on fnvht_pkg and the assertion macro header.
module fnvht_back #(
  parameter int SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  fnvht_pkg::cmd_t  cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [63:0]      found_value,
  output logic [3:0]       slot,
  output logic [4:0]       entries
);
  import fnvht_pkg::*;
  `include "fnv_open_address_hash_table_macros.svh"
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]     state;
  logic [AW-1:0]  ptr;
  logic [SLOTS-1:0] valid_bits;
  logic [CW-1:0]  count;
  logic [63:0]    key_store [SLOTS];
  logic [63:0]    value_store [SLOTS];
  logic [63:0]    rd_key;
  logic [63:0]    rd_value;
  logic           rd_ok;
  logic           hit;
  logic           last;
  logic           is_ins;
  logic [AW:0]    slot_wide;

  // Pop the queue entry only when its result is taken.
  assign cmd_ready = (state == S_OUT) && out_ready;
  assign out_valid = (state == S_OUT);
  assign hit    = rd_ok && ((rd_key & cmd.mask) == (cmd.key & cmd.mask));
  assign last   = (ptr == AW'(SLOTS - 1));
  assign is_ins = (cmd.action == ACT_INSERT);
  assign slot_wide = {1'b0, ptr};
  assign entries = 5'(count);

  always_ff @(posedge clk) begin
    rd_key   <= key_store[ptr];
    rd_value <= value_store[ptr];
    rd_ok    <= valid_bits[ptr];
    if (state == S_CHECK && is_ins && (!rd_ok || hit)) begin
      key_store[ptr]   <= cmd.key;
      value_store[ptr] <= cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid_bits <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd_valid) begin
          ptr <= cmd.hash[AW-1:0];
          state <= S_READ;
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          // Hold the queue entry until the result is taken.
          if (is_ins && (!rd_ok || hit)) begin
            if (!rd_ok) count <= count + CW'(1);
            valid_bits[ptr] <= 1'b1;
            status <= ST_DONE; found_value <= '0; slot <= 4'(slot_wide);
            state <= S_OUT;
          end else if (!is_ins && hit) begin
            status <= ST_DONE; slot <= 4'(slot_wide);
            if (cmd.action == ACT_DELETE) begin
              valid_bits[ptr] <= 1'b0;
              count <= count - CW'(1);
              found_value <= '0;
            end else begin
              found_value <= rd_value;
            end
            state <= S_OUT;
          end else if (last) begin
            status <= is_ins ? ST_FULL : ST_MISSING;
            found_value <= '0; slot <= 4'd0;
            state <= S_OUT;
          end else begin
            ptr <= ptr + AW'(1);
            state <= S_READ;
          end
        end
        S_OUT: if (out_ready) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FNV_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(SLOTS))
  `FNV_ASSERT_IMP(a_count_match, clk, rst, state == S_IDLE, count == CW'($countones(valid_bits)))
  `FNV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status))
endmodule

/* rtl/fnv_open_address_hash_table.sv */
// Open-address key/value table, FNV-1a 64 hashed, linear probe without wrap.
// Front and back each work on one word at a time: the front takes a new word only once
// its last hash is in the queue; the back pops a word only when its result is taken.
// Hash and probe overlap across the queue; a full probe sets the rate.
// Reset (rst, synchronous): clears valid bits and count, sets key_bytes to 8.
// Depends on fnvht_pkg, fnvht_front, fnvht_queue, fnvht_back.
module fnv_open_address_hash_table #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [63:0] key,
  input  logic [63:0] value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] found_value,
  output logic [3:0]  slot,
  output logic [4:0]  entries
);
  import fnvht_pkg::*;
  logic [3:0] key_bytes;
  cmd_t f_cmd, b_cmd;
  logic f_valid, f_ready, b_valid, b_ready;

  // Take config writes any time.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) key_bytes <= 4'd8;
    else if (cfg_valid) key_bytes <= cfg_data;
  end

  fnvht_front u_front (.clk, .rst, .in_valid, .in_ready, .action, .key, .value,
    .key_bytes, .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));
  fnvht_queue u_queue (.clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data(f_cmd), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd));
  fnvht_back #(.SLOTS(SLOTS)) u_back (.clk, .rst, .cmd_valid(b_valid),
    .cmd_ready(b_ready), .cmd(b_cmd), .out_valid, .out_ready, .status,
    .found_value, .slot, .entries);
endmodule
